### sv/i2c_master_combined_transfer_unit_defines.svh
// ----------------------------------------------------------------------------
// I2C combined transfer unit - assertion macros
// Shared concurrent check macros; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_COMBINED_TRANSFER_UNIT_DEFINES_SVH
`define I2C_MASTER_COMBINED_TRANSFER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define I2CMCT_CHK_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c transfer unit check failed");

// next-cycle implication
`define I2CMCT_CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c transfer unit check failed");

`else

`define I2CMCT_CHK_IMPLY(name, ante, cons)
`define I2CMCT_CHK_NEXT(name, ante, cons)

`endif

`endif

### sv/i2cmct_pkg.sv
// ----------------------------------------------------------------------------
// I2C combined transfer unit - package
// Item types, kind codes and buffer sizing.
// ----------------------------------------------------------------------------
package i2cmct_pkg;

  localparam int WRITE_DEPTH = 32;
  localparam int IDX_W       = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam int PTR_W       = $clog2(WRITE_DEPTH + 1);

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_BEGIN = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] write_byte;
    logic [7:0] device_address;
    logic [5:0] write_count;
    logic [7:0] read_count;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_data;
    logic       read_valid;
    logic       done_res;
    logic       success;
    logic       busy_res;
  } out_item_t;

endpackage

### sv/i2c_master_combined_transfer_unit.sv
// ----------------------------------------------------------------------------
// I2C combined transfer unit
// I2C master sequencer: buffered write bytes, then START, address + write,
// data bytes, repeated START, address + read, read bytes. One line change
// per tick item. No STOP is generated.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------
//  input   | in_valid / in_ready / in_item  | kind, write byte, address,
//          |                                | counts, sampled SDA
//  result  | out_valid / out_ready/ out_item| SCL/SDA levels, read byte,
//          |                                | done, success, busy
//
//  Every item is handled as it is accepted: the sequencer state and the result
//  register update together at that edge, so one item per cycle when not stalled.
//  Each accepted item produces exactly one result item.
//  in_ready is high whenever the result register is empty or being drained;
//  a stalled result holds the input side for as long as it waits.
//  rst_n (synchronous) returns the sequencer to idle with both lines released
//  and the load pointer at zero; buffer contents are kept as they are.
// ----------------------------------------------------------------------------
`include "i2c_master_combined_transfer_unit_defines.svh"

module i2c_master_combined_transfer_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cmct_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cmct_pkg::out_item_t out_item
);

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_W,
    PH_START_R,
    PH_TXBIT_W,
    PH_TXACK_W,
    PH_TXBIT_R,
    PH_TXACK_R,
    PH_RXBIT,
    PH_RXACK
  } phase_t;

  // write byte buffer, no reset: the user must load entries before they are sent; the block does not enforce it
  logic [7:0] wbuf_r [i2cmct_pkg::WRITE_DEPTH];

  phase_t                       phase_r,    phase_nxt;
  logic [1:0]                   substep_r,  substep_nxt;
  logic [3:0]                   bit_cnt_r,  bit_cnt_nxt;
  logic [7:0]                   byte_cnt_r, byte_cnt_nxt;
  logic [7:0]                   shift_r,    shift_nxt;
  logic [7:0]                   addr_r,     addr_nxt;
  logic [i2cmct_pkg::PTR_W-1:0] load_ptr_r, load_ptr_nxt;
  logic [i2cmct_pkg::PTR_W-1:0] wr_total_r, wr_total_nxt;
  logic [7:0]                   rd_total_r, rd_total_nxt;
  logic                         scl_r,      scl_nxt;
  logic                         sda_r,      sda_nxt;

  logic                  out_valid_r;
  i2cmct_pkg::out_item_t out_r, res_nxt;

  logic       in_fire;
  logic       buf_we;
  logic [7:0] buf_rd_r;
  logic [3:0] bit_dec;
  logic [7:0] byte_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign bit_dec  = (bit_cnt_r != 4'd0) ? bit_cnt_r - 4'd1 : 4'd0;
  assign byte_inc = byte_cnt_r + 8'd1;

  // --------------------------------------------------------------------------
  // Next-state and result logic for one item
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt    = phase_r;
    substep_nxt  = substep_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    addr_nxt     = addr_r;
    load_ptr_nxt = load_ptr_r;
    wr_total_nxt = wr_total_r;
    rd_total_nxt = rd_total_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    buf_we       = 1'b0;
    res_nxt      = '0;

    unique case (in_item.kind)
      i2cmct_pkg::KIND_LOAD: begin
        if (phase_r == PH_IDLE && 32'(load_ptr_r) < i2cmct_pkg::WRITE_DEPTH) begin
          buf_we       = 1'b1;
          load_ptr_nxt = load_ptr_r + i2cmct_pkg::PTR_W'(1);
        end
      end
      i2cmct_pkg::KIND_BEGIN: begin
        if (phase_r == PH_IDLE) begin
          addr_nxt = in_item.device_address;
          // count saturates at the buffer depth
          if (32'(in_item.write_count) > i2cmct_pkg::WRITE_DEPTH) begin
            wr_total_nxt = i2cmct_pkg::PTR_W'(i2cmct_pkg::WRITE_DEPTH);
          end else begin
            wr_total_nxt = i2cmct_pkg::PTR_W'(in_item.write_count);
          end
          rd_total_nxt = in_item.read_count;
          load_ptr_nxt = '0;
          byte_cnt_nxt = '0;
          bit_cnt_nxt  = '0;
          shift_nxt    = '0;
          substep_nxt  = '0;
          // address probe (both counts zero) goes through the write phase
          if (wr_total_nxt != '0 || in_item.read_count == 8'd0) begin
            phase_nxt = PH_START_W;
          end else begin
            phase_nxt = PH_START_R;
          end
        end
      end
      i2cmct_pkg::KIND_TICK: begin
        unique case (phase_r)
          PH_IDLE: begin
          end
          PH_START_W, PH_START_R: begin
            // SDA high, SCL high, SDA low, SCL low
            case (substep_r)
              2'd0: sda_nxt = 1'b1;
              2'd1: scl_nxt = 1'b1;
              2'd2: sda_nxt = 1'b0;
              default: scl_nxt = 1'b0;
            endcase
            if (substep_r == 2'd3) begin
              bit_cnt_nxt = 4'd8;
              substep_nxt = 2'd0;
              if (phase_r == PH_START_W) begin
                shift_nxt = addr_r & i2cmct_pkg::ADDR_WR_MASK;
                phase_nxt = PH_TXBIT_W;
              end else begin
                shift_nxt = addr_r | i2cmct_pkg::ADDR_RD_BIT;
                phase_nxt = PH_TXBIT_R;
              end
            end else begin
              substep_nxt = substep_r + 2'd1;
            end
          end
          PH_TXBIT_W, PH_TXBIT_R: begin
            if (substep_r == 2'd0) begin
              sda_nxt     = shift_r[7];
              substep_nxt = 2'd1;
            end else if (substep_r == 2'd1) begin
              scl_nxt     = 1'b1;
              substep_nxt = 2'd2;
            end else begin
              scl_nxt     = 1'b0;
              shift_nxt   = {shift_r[6:0], 1'b0};
              substep_nxt = 2'd0;
              bit_cnt_nxt = bit_dec;
              if (bit_dec == 4'd0) begin
                phase_nxt = (phase_r == PH_TXBIT_W) ? PH_TXACK_W : PH_TXACK_R;
              end
            end
          end
          PH_TXACK_W, PH_TXACK_R: begin
            if (substep_r == 2'd0) begin
              sda_nxt     = 1'b1;
              substep_nxt = 2'd1;
            end else if (substep_r == 2'd1) begin
              scl_nxt     = 1'b1;
              substep_nxt = 2'd2;
            end else begin
              scl_nxt     = 1'b0;
              substep_nxt = 2'd0;
              if (in_item.sda_in) begin
                // slave NAK: abort
                res_nxt.done_res = 1'b1;
                phase_nxt        = PH_IDLE;
              end else if (phase_r == PH_TXACK_R) begin
                byte_cnt_nxt = '0;
                shift_nxt    = '0;
                bit_cnt_nxt  = 4'd8;
                phase_nxt    = PH_RXBIT;
              end else if (32'(byte_cnt_r) < 32'(wr_total_r)
                           && 32'(byte_cnt_r) < i2cmct_pkg::WRITE_DEPTH) begin
                byte_cnt_nxt = byte_inc;
                shift_nxt    = buf_rd_r;
                bit_cnt_nxt  = 4'd8;
                phase_nxt    = PH_TXBIT_W;
              end else if (rd_total_r != 8'd0) begin
                phase_nxt = PH_START_R;
              end else begin
                res_nxt.done_res = 1'b1;
                res_nxt.success  = 1'b1;
                phase_nxt        = PH_IDLE;
              end
            end
          end
          PH_RXBIT: begin
            if (substep_r == 2'd0) begin
              scl_nxt     = 1'b1;
              substep_nxt = 2'd1;
            end else begin
              // sample SDA as the level held while SCL was high
              scl_nxt     = 1'b0;
              substep_nxt = 2'd0;
              shift_nxt   = {shift_r[6:0], in_item.sda_in};
              bit_cnt_nxt = bit_dec;
              if (bit_dec == 4'd0) begin
                res_nxt.read_valid = 1'b1;
                res_nxt.read_data  = {shift_r[6:0], in_item.sda_in};
                phase_nxt          = PH_RXACK;
              end
            end
          end
          PH_RXACK: begin
            case (substep_r)
              2'd0: begin
                // NAK the last byte, ACK the rest
                sda_nxt     = ({1'b0, byte_inc} >= {1'b0, rd_total_r}) ? 1'b1 : 1'b0;
                substep_nxt = 2'd1;
              end
              2'd1: begin
                scl_nxt     = 1'b1;
                substep_nxt = 2'd2;
              end
              2'd2: begin
                scl_nxt     = 1'b0;
                substep_nxt = 2'd3;
              end
              default: begin
                sda_nxt      = 1'b1;
                substep_nxt  = 2'd0;
                byte_cnt_nxt = byte_inc;
                if (byte_inc >= rd_total_r) begin
                  res_nxt.done_res = 1'b1;
                  res_nxt.success  = 1'b1;
                  phase_nxt        = PH_IDLE;
                end else begin
                  shift_nxt   = '0;
                  bit_cnt_nxt = 4'd8;
                  phase_nxt   = PH_RXBIT;
                end
              end
            endcase
          end
          default: begin
            phase_nxt   = PH_IDLE;
            substep_nxt = 2'd0;
          end
        endcase
      end
      default: begin
      end
    endcase

    res_nxt.scl_out  = scl_nxt;
    res_nxt.sda_out  = sda_nxt;
    res_nxt.busy_res = (phase_nxt != PH_IDLE);
  end

  // --------------------------------------------------------------------------
  // Write buffer. The byte counter settles at least 27 items before the ack
  // slot that fetches the next byte, so the registered read is always current.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire && buf_we) begin
      wbuf_r[load_ptr_r[i2cmct_pkg::IDX_W-1:0]] <= in_item.write_byte;
    end
    buf_rd_r <= wbuf_r[byte_cnt_r[i2cmct_pkg::IDX_W-1:0]];
  end

  // --------------------------------------------------------------------------
  // Sequencer state and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      substep_r   <= '0;
      bit_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      shift_r     <= '0;
      addr_r      <= '0;
      load_ptr_r  <= '0;
      wr_total_r  <= '0;
      rd_total_r  <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        substep_r   <= substep_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        byte_cnt_r  <= byte_cnt_nxt;
        shift_r     <= shift_nxt;
        addr_r      <= addr_nxt;
        load_ptr_r  <= load_ptr_nxt;
        wr_total_r  <= wr_total_nxt;
        rd_total_r  <= rd_total_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        out_r       <= res_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // idle always parks the line sequencer at its first step
  `I2CMCT_CHK_IMPLY(a_idle_substep, phase_r == PH_IDLE, substep_r == 2'd0)
  // bit counter never exceeds one byte
  `I2CMCT_CHK_IMPLY(a_bit_cnt_range, 1'b1, bit_cnt_r <= 4'd8)
  // a pending received byte means the sequencer moved on to the ACK slot
  `I2CMCT_CHK_IMPLY(a_rd_then_ack, out_valid_r && out_r.read_valid, phase_r == PH_RXACK)
  // a finished transfer leaves the sequencer idle
  `I2CMCT_CHK_NEXT(a_done_idle, in_fire && res_nxt.done_res, phase_r == PH_IDLE)

endmodule
